// File: rtl/hbk_pkg.sv
// ----------------------------------------------------------------------------
// hbk_pkg
// Shared formats, reset values, divider reciprocals and helpers for the
// head-head B/C tool kinematics pipeline.
// ----------------------------------------------------------------------------
package hbk_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int ANG_W  = DATA_W + 1;
  localparam int IDX_W  = 3;
  localparam int AXIS_W = 18;

  typedef enum logic [IDX_W-1:0] {
    REG_PIVOT_X = 3'd0,
    REG_PIVOT_Y = 3'd1,
    REG_PIVOT_Z = 3'd2,
    REG_TOOL_X  = 3'd3,
    REG_TOOL_Y  = 3'd4,
    REG_TOOL_Z  = 3'd5,
    REG_B_ZERO  = 3'd6,
    REG_C_ZERO  = 3'd7
  } reg_idx_t;

  localparam logic CMD_INVERSE = 1'b1;

  localparam longint TOOL_Y_RAW = longint'(25) * (longint'(1) << FRAC_BITS);
  localparam longint TOOL_Z_RAW = longint'(-180) * (longint'(1) << FRAC_BITS);
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [DATA_W-1:0] TOOL_Y_RST =
    DATA_W'((TOOL_Y_RAW > S32_MAX) ? S32_MAX : TOOL_Y_RAW);
  localparam logic [DATA_W-1:0] TOOL_Z_RST =
    DATA_W'((TOOL_Z_RAW < S32_MIN) ? S32_MIN : TOOL_Z_RAW);

  // angle reduction: floor(a / 90deg) through a positive offset
  localparam longint Q90 = longint'(90) << FRAC_BITS;
  localparam longint Q45 = longint'(45) << FRAC_BITS;
  localparam longint OFS_GRP = 4 * (((longint'(1) << 32) + 4 * Q90 - 1) / (4 * Q90));
  localparam longint OFS = OFS_GRP * Q90;
  localparam int AU_W   = ANG_W + 1;
  localparam int T_W    = AU_W - FRAC_BITS - 1;
  localparam int RQ_SH  = T_W + 6;
  localparam int RQ_W   = T_W + 1;
  localparam longint RQ = ((longint'(1) << RQ_SH) + 44) / 45;
  localparam int KK_W   = T_W - 5;
  localparam int REM_W  = FRAC_BITS + 7;
  localparam int REM2_W = FRAC_BITS + 6;
  localparam int DEG_W  = 27;
  localparam logic [DEG_W-1:0] DEG2RAD_Q32 = 27'd74961321;
  localparam int X_W    = 30;
  localparam int TERM_W = 31;
  localparam logic [TERM_W-1:0] ONE30 = 31'h4000_0000;

  // Taylor steps, highest order first: term / D by reciprocal R >> M
  localparam int NSTEP = 6;
  localparam int STEP_W = 3;
  localparam longint unsigned S_R [NSTEP] = '{
    ((64'd1 << 39) + 155) / 156, ((64'd1 << 38) + 109) / 110,
    ((64'd1 << 38) + 71) / 72,   ((64'd1 << 37) + 41) / 42,
    ((64'd1 << 36) + 19) / 20,   ((64'd1 << 34) + 5) / 6};
  localparam int S_M [NSTEP] = '{39, 38, 38, 37, 36, 34};
  localparam longint unsigned C_R [NSTEP] = '{
    ((64'd1 << 39) + 131) / 132, ((64'd1 << 38) + 89) / 90,
    ((64'd1 << 37) + 55) / 56,   ((64'd1 << 36) + 29) / 30,
    ((64'd1 << 35) + 11) / 12,   ((64'd1 << 32) + 1) / 2};
  localparam int C_M [NSTEP] = '{39, 38, 37, 36, 35, 32};

  localparam int ANG_LAT = 5;
  localparam int SC_LAT  = ANG_LAT + 1 + 2 * NSTEP + 2;
  localparam int ROT_LAT = 7;

  localparam int WIDE_W = 68;

  typedef struct packed {
    logic                     cmd;
    logic                     comp;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
  } side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pivot_x;
    logic signed [DATA_W-1:0] pivot_y;
    logic signed [DATA_W-1:0] pivot_z;
    logic signed [DATA_W-1:0] tool_x;
    logic signed [DATA_W-1:0] tool_y;
    logic signed [DATA_W-1:0] tool_z;
  } cfg_t;

  function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
                                                        input int sh);
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] r;
    mag = v[WIDE_W-1] ? (~v + WIDE_W'(1)) : v;
    r = (mag + (WIDE_W'(1) << (sh - 1))) >> sh;
    return v[WIDE_W-1] ? $signed(~r + WIDE_W'(1)) : $signed(r);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [AXIS_W-1:0] sat18(input logic signed [WIDE_W-1:0] v);
    if (v > 68'sd131071) begin
      return 18'sh1ffff;
    end else if (v < -68'sd131072) begin
      return 18'sh20000;
    end
    return v[AXIS_W-1:0];
  endfunction

endpackage

// File: rtl/hbk_angle.sv
// ----------------------------------------------------------------------------
// hbk_angle
// Reduces an angle in degrees to quadrant, fold flag and an octant argument
// in radians, Q30, over five stages.
// ----------------------------------------------------------------------------
module hbk_angle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld_in,
  input  logic signed [hbk_pkg::ANG_W-1:0]  ang,
  output logic                              vld_out,
  output logic [hbk_pkg::X_W-1:0]           x,
  output logic [1:0]                        quad,
  output logic                              fold
);
  import hbk_pkg::*;

  logic [ANG_LAT-1:0]          vld;
  logic [AU_W-1:0]             au;
  logic [T_W-1:0]              t1, t2;
  logic [FRAC_BITS:0]          low1, low2;
  logic [T_W+RQ_W-1:0]         qprod;
  logic [KK_W-1:0]             kk2;
  logic [T_W-1:0]              kk45;
  logic [5:0]                  r45;
  logic [REM_W-1:0]            rem3;
  logic [1:0]                  quad3, quad4, quad5;
  logic [REM2_W-1:0]           rem4;
  logic                        fold_c, fold4, fold5;
  logic [REM2_W+DEG_W-1:0]     xprod;
  logic [X_W-1:0]              x5;

  always_comb begin
    au    = {ang[ANG_W-1], ang} + AU_W'(OFS);
    qprod = (T_W+RQ_W)'(t1) * (T_W+RQ_W)'(RQ);
    kk45  = T_W'(kk2) * T_W'(45);
    r45   = 6'(t2 - kk45);
    fold_c = rem3 > REM_W'(Q45);
    xprod = (REM2_W+DEG_W)'(rem4) * (REM2_W+DEG_W)'(DEG2RAD_Q32)
          + ((REM2_W+DEG_W)'(1) << (FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ANG_LAT-2:0], vld_in};
    end
    t1    <= au[AU_W-1:FRAC_BITS+1];
    low1  <= au[FRAC_BITS:0];
    t2    <= t1;
    low2  <= low1;
    kk2   <= qprod[T_W+RQ_W-1:RQ_SH];
    rem3  <= {r45, low2};
    quad3 <= kk2[1:0];
    fold4 <= fold_c;
    rem4  <= fold_c ? REM2_W'(REM_W'(Q90) - rem3) : REM2_W'(rem3);
    quad4 <= quad3;
    fold5 <= fold4;
    quad5 <= quad4;
    x5    <= xprod[FRAC_BITS+2+X_W-1:FRAC_BITS+2];
  end

  assign vld_out = vld[ANG_LAT-1];
  assign x       = x5;
  assign quad    = quad5;
  assign fold    = fold5;

endmodule

// File: rtl/hbk_taylor_step.sv
// ----------------------------------------------------------------------------
// hbk_taylor_step
// One nested Taylor step for sine and cosine: multiply by x squared, divide
// by the step constant through a reciprocal, subtract from one.
// ----------------------------------------------------------------------------
module hbk_taylor_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hbk_pkg::STEP_W-1:0]    step,
  input  logic                          vld_in,
  input  logic [hbk_pkg::X_W-1:0]       x_in,
  input  logic [hbk_pkg::X_W-1:0]       x2_in,
  input  logic [hbk_pkg::TERM_W-1:0]    ts_in,
  input  logic [hbk_pkg::TERM_W-1:0]    tc_in,
  output logic                          vld_out,
  output logic [hbk_pkg::X_W-1:0]       x_out,
  output logic [hbk_pkg::X_W-1:0]       x2_out,
  output logic [hbk_pkg::TERM_W-1:0]    ts_out,
  output logic [hbk_pkg::TERM_W-1:0]    tc_out
);
  import hbk_pkg::*;

  logic [X_W+TERM_W-1:0]   ms, mc;
  logic [TERM_W-1:0]       ps, pc;
  logic [X_W-1:0]          x1, x21;
  logic                    v1, v2;
  logic [2*TERM_W:0]       qs_p, qc_p;
  logic [TERM_W-1:0]       qs, qc;
  logic [X_W-1:0]          x_q, x2_q;
  logic [TERM_W-1:0]       ts_q, tc_q;

  always_comb begin
    ms   = (X_W+TERM_W)'(x2_in) * (X_W+TERM_W)'(ts_in);
    mc   = (X_W+TERM_W)'(x2_in) * (X_W+TERM_W)'(tc_in);
    qs_p = (2*TERM_W+1)'(ps) * (2*TERM_W+1)'(S_R[step]);
    qc_p = (2*TERM_W+1)'(pc) * (2*TERM_W+1)'(C_R[step]);
    qs   = TERM_W'(qs_p >> S_M[step]);
    qc   = TERM_W'(qc_p >> C_M[step]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= vld_in;
      v2 <= v1;
    end
    ps   <= ms[X_W+TERM_W-1:30];
    pc   <= mc[X_W+TERM_W-1:30];
    x1   <= x_in;
    x21  <= x2_in;
    ts_q <= ONE30 - qs;
    tc_q <= ONE30 - qc;
    x_q  <= x1;
    x2_q <= x21;
  end

  assign vld_out = v2;
  assign x_out   = x_q;
  assign x2_out  = x2_q;
  assign ts_out  = ts_q;
  assign tc_out  = tc_q;

endmodule

// File: rtl/hbk_sincos.sv
// ----------------------------------------------------------------------------
// hbk_sincos
// Sine and cosine of an angle in degrees, Q2.30, through angle reduction,
// six Taylor steps and quadrant mapping.
// ----------------------------------------------------------------------------
module hbk_sincos (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vld_in,
  input  logic signed [hbk_pkg::ANG_W-1:0]   ang,
  output logic                               vld_out,
  output logic signed [hbk_pkg::DATA_W-1:0]  sin_o,
  output logic signed [hbk_pkg::DATA_W-1:0]  cos_o
);
  import hbk_pkg::*;

  localparam int QD = 2 * NSTEP + 2;

  logic              a_vld, a_fold;
  logic [X_W-1:0]    a_x;
  logic [1:0]        a_quad;
  logic [2*X_W:0]    sq;
  logic              vld_c [NSTEP+1];
  logic [X_W-1:0]    x_c   [NSTEP+1];
  logic [X_W-1:0]    x2_c  [NSTEP+1];
  logic [TERM_W-1:0] ts_c  [NSTEP+1];
  logic [TERM_W-1:0] tc_c  [NSTEP+1];
  logic [2:0]        qf_dl [QD];
  logic [X_W+TERM_W-1:0] sp;
  logic              f1_vld, f2_vld;
  logic [TERM_W-1:0] s0, c0;
  logic signed [DATA_W-1:0] s1, c1, s_q, c_q;

  hbk_angle u_angle (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld_in),
    .ang     (ang),
    .vld_out (a_vld),
    .x       (a_x),
    .quad    (a_quad),
    .fold    (a_fold)
  );

  assign sq = (2*X_W+1)'(a_x) * (2*X_W+1)'(a_x) + ((2*X_W+1)'(1) << 29);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c[0] <= 1'b0;
    end else begin
      vld_c[0] <= a_vld;
    end
    x_c[0]  <= a_x;
    x2_c[0] <= sq[2*X_W-1:30];
    ts_c[0] <= ONE30;
    tc_c[0] <= ONE30;
  end

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    hbk_taylor_step u_step (
      .clk     (clk),
      .rst     (rst),
      .step    (STEP_W'(g)),
      .vld_in  (vld_c[g]),
      .x_in    (x_c[g]),
      .x2_in   (x2_c[g]),
      .ts_in   (ts_c[g]),
      .tc_in   (tc_c[g]),
      .vld_out (vld_c[g+1]),
      .x_out   (x_c[g+1]),
      .x2_out  (x2_c[g+1]),
      .ts_out  (ts_c[g+1]),
      .tc_out  (tc_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    qf_dl[0] <= {a_fold, a_quad};
    for (int i = 1; i < QD; i++) begin
      qf_dl[i] <= qf_dl[i-1];
    end
  end

  assign sp = (X_W+TERM_W)'(x_c[NSTEP]) * (X_W+TERM_W)'(ts_c[NSTEP]);

  always_comb begin
    s1 = qf_dl[QD-1][2] ? $signed({1'b0, c0}) : $signed({1'b0, s0});
    c1 = qf_dl[QD-1][2] ? $signed({1'b0, s0}) : $signed({1'b0, c0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else begin
      f1_vld <= vld_c[NSTEP];
      f2_vld <= f1_vld;
    end
    s0 <= sp[X_W+TERM_W-1:30];
    c0 <= tc_c[NSTEP];
    unique case (qf_dl[QD-1][1:0])
      2'd0: begin
        s_q <= s1;
        c_q <= c1;
      end
      2'd1: begin
        s_q <= c1;
        c_q <= -s1;
      end
      2'd2: begin
        s_q <= -s1;
        c_q <= -c1;
      end
      2'd3: begin
        s_q <= -c1;
        c_q <= s1;
      end
    endcase
  end

  assign vld_out = f2_vld;
  assign sin_o   = s_q;
  assign cos_o   = c_q;

endmodule

// File: rtl/hbk_rotate.sv
// ----------------------------------------------------------------------------
// hbk_rotate
// B rotation of the tool vector, pivot add, C rotation, tool axis and the
// compensated, saturated result registers.
// ----------------------------------------------------------------------------
module hbk_rotate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               vld_in,
  input  hbk_pkg::side_t                     side,
  input  hbk_pkg::cfg_t                      cfg,
  input  logic signed [hbk_pkg::DATA_W-1:0]  sb,
  input  logic signed [hbk_pkg::DATA_W-1:0]  cb,
  input  logic signed [hbk_pkg::DATA_W-1:0]  sc,
  input  logic signed [hbk_pkg::DATA_W-1:0]  cc,
  output logic                               done,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_x,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_y,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_z,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_b,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_c,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_x,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_y,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_z,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_x,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_y,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_z
);
  import hbk_pkg::*;

  localparam int P_W   = 2 * DATA_W;
  localparam int V_W   = 35;
  localparam int M_W   = DATA_W + V_W;
  localparam int AXR_W = FRAC_BITS + 3;

  logic [ROT_LAT-1:0]        vld;
  side_t                     side_q [ROT_LAT-1];
  logic signed [P_W-1:0]     p_cbtx, p_sbtz, p_cbtz, p_sbtx, p_ccsb, p_scsb;
  logic signed [DATA_W-1:0]  cb1;
  logic signed [P_W:0]       s0, s2;
  logic signed [AXR_W-1:0]   axr_x, axr_y, axr_z;
  logic signed [AXIS_W-1:0]  ax_x [ROT_LAT-3];
  logic signed [AXIS_W-1:0]  ax_y [ROT_LAT-3];
  logic signed [AXIS_W-1:0]  ax_z [ROT_LAT-3];
  logic signed [V_W-1:0]     v0, v1, v2, v2_4, v2_5, v2_6;
  logic signed [DATA_W-1:0]  cc3, sc3, cc4, sc4, cc2, sc2;
  logic signed [M_W-1:0]     m_ccv0, m_scv1, m_scv0, m_ccv1;
  logic signed [M_W:0]       o0, o1;
  logic signed [WIDE_W-1:0]  off0, off1, off2, coord_x, coord_y, coord_z;
  logic signed [WIDE_W-1:0]  r_x, r_y, r_z;
  side_t                     s6;

  assign s6 = side_q[ROT_LAT-2];

  always_comb begin
    coord_x = WIDE_W'(s6.x);
    coord_y = WIDE_W'(s6.y);
    coord_z = WIDE_W'(s6.z);
    r_x = coord_x;
    r_y = coord_y;
    r_z = coord_z;
    if (s6.comp) begin
      if (s6.cmd == CMD_INVERSE) begin
        r_x = coord_x - off0;
        r_y = coord_y - off1;
        r_z = coord_z - off2;
      end else begin
        r_x = coord_x + off0;
        r_y = coord_y + off1;
        r_z = coord_z + off2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ROT_LAT-2:0], vld_in};
    end
    side_q[0] <= side;
    for (int i = 1; i < ROT_LAT - 1; i++) begin
      side_q[i] <= side_q[i-1];
    end
    // stage 1
    p_cbtx <= P_W'(cb) * P_W'(cfg.tool_x);
    p_sbtz <= P_W'(sb) * P_W'(cfg.tool_z);
    p_cbtz <= P_W'(cb) * P_W'(cfg.tool_z);
    p_sbtx <= P_W'(sb) * P_W'(cfg.tool_x);
    p_ccsb <= P_W'(cc) * P_W'(sb);
    p_scsb <= P_W'(sc) * P_W'(sb);
    cb1    <= cb;
    cc2    <= cc;
    sc2    <= sc;
    // stage 2
    s0    <= (P_W+1)'(p_cbtx) + (P_W+1)'(p_sbtz);
    s2    <= (P_W+1)'(p_cbtz) - (P_W+1)'(p_sbtx);
    axr_x <= AXR_W'(rnd_shr(WIDE_W'(p_ccsb), 60 - FRAC_BITS));
    axr_y <= AXR_W'(rnd_shr(WIDE_W'(p_scsb), 60 - FRAC_BITS));
    axr_z <= AXR_W'(rnd_shr(WIDE_W'(cb1), 30 - FRAC_BITS));
    cc3   <= cc2;
    sc3   <= sc2;
    // stage 3
    v0 <= V_W'(rnd_shr(WIDE_W'(s0), 30)) + V_W'(cfg.pivot_x);
    v1 <= V_W'(cfg.tool_y) + V_W'(cfg.pivot_y);
    v2 <= V_W'(rnd_shr(WIDE_W'(s2), 30)) + V_W'(cfg.pivot_z);
    ax_x[0] <= sat18(-WIDE_W'(axr_x));
    ax_y[0] <= sat18(-WIDE_W'(axr_y));
    ax_z[0] <= sat18(-WIDE_W'(axr_z));
    for (int i = 1; i < ROT_LAT - 3; i++) begin
      ax_x[i] <= ax_x[i-1];
      ax_y[i] <= ax_y[i-1];
      ax_z[i] <= ax_z[i-1];
    end
    cc4 <= cc3;
    sc4 <= sc3;
    // stage 4
    m_ccv0 <= M_W'(cc4) * M_W'(v0);
    m_scv1 <= M_W'(sc4) * M_W'(v1);
    m_scv0 <= M_W'(sc4) * M_W'(v0);
    m_ccv1 <= M_W'(cc4) * M_W'(v1);
    v2_4   <= v2;
    // stage 5
    o0   <= (M_W+1)'(m_ccv0) - (M_W+1)'(m_scv1);
    o1   <= (M_W+1)'(m_scv0) + (M_W+1)'(m_ccv1);
    v2_5 <= v2_4;
    // stage 6
    off0 <= rnd_shr(WIDE_W'(o0), 30);
    off1 <= rnd_shr(WIDE_W'(o1), 30);
    v2_6 <= v2_5;
    off2 <= WIDE_W'(v2_5);
    // stage 7
    out_x    <= sat32(r_x);
    out_y    <= sat32(r_y);
    out_z    <= sat32(r_z);
    out_b    <= s6.b;
    out_c    <= s6.c;
    offset_x <= sat32(off0);
    offset_y <= sat32(off1);
    offset_z <= sat32(WIDE_W'(v2_6));
    axis_x   <= ax_x[ROT_LAT-4];
    axis_y   <= ax_y[ROT_LAT-4];
    axis_z   <= ax_z[ROT_LAT-4];
  end

  assign done = vld[ROT_LAT-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld_in |-> ##ROT_LAT done)
    else $error("result strobe lost in rotation pipeline");

  a_pass: assert property (@(posedge clk) disable iff (rst)
    (vld[ROT_LAT-2] && !s6.comp) |=> (out_x == $past(s6.x) && out_z == $past(s6.z)))
    else $error("uncompensated item altered");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    done |-> (axis_z <= 18'sd65536 && axis_z >= -18'sd65536 &&
              axis_x <= 18'sd65536 && axis_x >= -18'sd65536))
    else $error("tool axis outside unit range");
`endif

endmodule

// File: rtl/head_head_bc_tool_kinematics.sv
// ----------------------------------------------------------------------------
// head_head_bc_tool_kinematics
// Five-axis head-head B/C tool center point transform, forward or inverse.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle; busy stays low. Each result leaves
// on a one-cycle done strobe, passing first the registered angle offset
// sums, then the sine/cosine pipeline (angle reduction, six two-stage
// Taylor steps and quadrant mapping), and then the two rotations
// and output saturation. The receiver cannot stall, so a result must be
// taken in the cycle that done is high.
module head_head_bc_tool_kinematics (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd,
  input  logic                               compensate,
  input  logic signed [hbk_pkg::DATA_W-1:0]  coord_x,
  input  logic signed [hbk_pkg::DATA_W-1:0]  coord_y,
  input  logic signed [hbk_pkg::DATA_W-1:0]  coord_z,
  input  logic signed [hbk_pkg::DATA_W-1:0]  angle_b,
  input  logic signed [hbk_pkg::DATA_W-1:0]  angle_c,
  input  logic                               wr_en,
  input  logic [hbk_pkg::IDX_W-1:0]          wr_index,
  input  logic [hbk_pkg::DATA_W-1:0]         wr_data,
  output logic                               done,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_x,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_y,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_z,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_b,
  output logic signed [hbk_pkg::DATA_W-1:0]  out_c,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_x,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_y,
  output logic signed [hbk_pkg::DATA_W-1:0]  offset_z,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_x,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_y,
  output logic signed [hbk_pkg::AXIS_W-1:0]  axis_z
);
  import hbk_pkg::*;

  cfg_t                     cfg;
  logic signed [DATA_W-1:0] b_zero, c_zero;
  logic                     vld0;
  logic signed [ANG_W-1:0]  sum_b, sum_c;
  side_t                    side0;
  side_t                    side_dl [SC_LAT];
  logic                     b_vld, c_vld;
  logic signed [DATA_W-1:0] sb, cb, sc, cc;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pivot_x <= '0;
      cfg.pivot_y <= '0;
      cfg.pivot_z <= '0;
      cfg.tool_x  <= '0;
      cfg.tool_y  <= TOOL_Y_RST;
      cfg.tool_z  <= TOOL_Z_RST;
      b_zero      <= '0;
      c_zero      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_PIVOT_X: cfg.pivot_x <= wr_data;
        REG_PIVOT_Y: cfg.pivot_y <= wr_data;
        REG_PIVOT_Z: cfg.pivot_z <= wr_data;
        REG_TOOL_X:  cfg.tool_x  <= wr_data;
        REG_TOOL_Y:  cfg.tool_y  <= wr_data;
        REG_TOOL_Z:  cfg.tool_z  <= wr_data;
        REG_B_ZERO:  b_zero      <= wr_data;
        REG_C_ZERO:  c_zero      <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy;
    end
    sum_b      <= ANG_W'(angle_b) + ANG_W'(b_zero);
    sum_c      <= ANG_W'(angle_c) + ANG_W'(c_zero);
    side0.cmd  <= cmd;
    side0.comp <= compensate;
    side0.x    <= coord_x;
    side0.y    <= coord_y;
    side0.z    <= coord_z;
    side0.b    <= angle_b;
    side0.c    <= angle_c;
    side_dl[0] <= side0;
    for (int i = 1; i < SC_LAT; i++) begin
      side_dl[i] <= side_dl[i-1];
    end
  end

  hbk_sincos u_sincos_b (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld0),
    .ang     (sum_b),
    .vld_out (b_vld),
    .sin_o   (sb),
    .cos_o   (cb)
  );

  hbk_sincos u_sincos_c (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld0),
    .ang     (sum_c),
    .vld_out (c_vld),
    .sin_o   (sc),
    .cos_o   (cc)
  );

  hbk_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (b_vld && c_vld),
    .side     (side_dl[SC_LAT-1]),
    .cfg      (cfg),
    .sb       (sb),
    .cb       (cb),
    .sc       (sc),
    .cc       (cc),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_b    (out_b),
    .out_c    (out_c),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .offset_z (offset_z),
    .axis_x   (axis_x),
    .axis_y   (axis_y),
    .axis_z   (axis_z)
  );

endmodule
